// ===== rtl/vcrs_pkg.sv =====
// Shared types and constants for the variant cluster region segmenter.
// Used by vcrs_core, vcrs_out_buf and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package vcrs_pkg;

    localparam int POSITION_BITS_DEF = 32;

    localparam int GAP_BITS       = 16;
    localparam int MIN_VAR_BITS   = 8;
    localparam int COUNT_BITS     = 16;
    localparam int CFG_ADDR_BITS  = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int IN_POS_BITS    = 31;
    localparam int OUT_BEGIN_BITS = 32;
    localparam int OUT_END_BITS   = 31;
    localparam int S_TDATA_BITS   = 96;
    localparam int M_TDATA_BITS   = 64;

    localparam logic [GAP_BITS-1:0]     MAX_GAP_RESET = 16'd13;
    localparam logic [MIN_VAR_BITS-1:0] MIN_VAR_RESET = 8'd2;
    localparam logic [COUNT_BITS-1:0]   COUNT_MAX     = 16'hFFFF;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_MAX_VARIANT_GAP = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MIN_VARIANTS    = 2'd1;

    localparam logic OP_ADVANCE = 1'b0;
    localparam logic OP_CLOSE   = 1'b1;

    localparam logic signed [63:0] INT32_MIN_64 = -64'sd2147483648;
    localparam logic signed [63:0] INT32_MAX_64 = 64'sd2147483647;

    typedef struct packed {
        logic signed [OUT_BEGIN_BITS-1:0] region_begin;
        logic [OUT_END_BITS-1:0]          region_end;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/vcrs_core.sv =====
// Region tracking state, configuration registers and per-position update logic.
// Depends on vcrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vcrs_core #(
    parameter int POSITION_BITS = vcrs_pkg::POSITION_BITS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [vcrs_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  wire logic [vcrs_pkg::CFG_DATA_BITS-1:0]   cfg_wr_data,
    input  wire logic                                 in_accept,
    input  wire logic                                 op,
    input  wire logic [vcrs_pkg::IN_POS_BITS-1:0]     position,
    input  wire logic                                 is_candidate,
    input  wire logic                                 is_depth_zero,
    input  wire logic                                 is_anchor,
    input  wire logic [vcrs_pkg::IN_POS_BITS-1:0]     buffer_begin,
    input  wire logic [vcrs_pkg::IN_POS_BITS-1:0]     buffer_end,
    output logic                                      res_valid,
    output vcrs_pkg::result_t                         res
);
    import vcrs_pkg::*;

    localparam int PW = POSITION_BITS;

    logic [GAP_BITS-1:0]     max_gap_reg;
    logic [MIN_VAR_BITS-1:0] min_var_reg;

    logic                 started_reg, started_next;
    logic signed [PW-1:0] region_start_reg, region_start_next;
    logic signed [PW-1:0] last_anchor_reg, last_anchor_next;
    logic signed [PW-1:0] anchor_after_reg, anchor_after_next;
    logic signed [PW-1:0] last_variant_reg, last_variant_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    logic signed [PW-1:0] emit_start, emit_anchor;
    logic                 emit_now;

    always_comb begin
        logic signed [PW-1:0] pos, p, bb_w, be_w;
        logic signed [PW:0]   d;
        logic                 cand, anc, far, su, eu, enough;

        started_next      = started_reg;
        region_start_next = region_start_reg;
        last_anchor_next  = last_anchor_reg;
        anchor_after_next = anchor_after_reg;
        last_variant_next = last_variant_reg;
        count_next        = count_reg;
        emit_now          = 1'b0;
        emit_start        = region_start_reg;
        emit_anchor       = anchor_after_reg;

        pos    = PW'(64'(position));
        p      = pos - PW'(1);
        bb_w   = PW'(64'(buffer_begin));
        be_w   = PW'($signed(64'(buffer_end)) - 64'sd1);
        enough = count_reg >= COUNT_BITS'(min_var_reg);
        cand   = 1'b0;
        anc    = 1'b0;
        far    = 1'b0;
        su     = 1'b0;
        eu     = 1'b0;
        d      = '0;

        if (in_accept) begin
            if (op == OP_CLOSE) begin
                if (started_reg) begin
                    if (enough) begin
                        su = region_start_reg[PW-1];
                        eu = anchor_after_reg[PW-1];
                        if (!su || !eu || (buffer_begin < buffer_end)) begin
                            emit_now    = 1'b1;
                            emit_start  = su ? bb_w : region_start_reg;
                            emit_anchor = eu ? be_w : anchor_after_reg;
                        end
                    end
                    region_start_next = '1;
                    last_anchor_next  = '1;
                    anchor_after_next = '1;
                    last_variant_next = '1;
                    count_next        = '0;
                end
            end else begin
                if (!started_reg) begin
                    region_start_next = pos;
                    anchor_after_next = pos;
                    last_anchor_next  = pos;
                    started_next      = 1'b1;
                end
                if (!p[PW-1]) begin
                    cand = is_candidate && !(is_depth_zero && (count_next == '0));
                    anc  = is_anchor && !cand;
                    if (cand || anc) begin
                        d   = {p[PW-1], p} - {last_variant_next[PW-1], last_variant_next};
                        far = d[PW] || (d[PW-1:0] > PW'(max_gap_reg));
                        if (far && !anchor_after_next[PW-1]) begin
                            if (count_next >= COUNT_BITS'(min_var_reg)) begin
                                emit_now          = 1'b1;
                                emit_start        = region_start_next;
                                emit_anchor       = anchor_after_next;
                                region_start_next = '0;
                            end
                            count_next = '0;
                        end
                        if (anc) begin
                            if (count_next == '0) begin
                                region_start_next = p;
                            end
                            if (anchor_after_next[PW-1]) begin
                                anchor_after_next = p;
                            end
                            last_anchor_next = p;
                        end
                        if (cand) begin
                            if (region_start_next == '0) begin
                                region_start_next = last_anchor_next;
                            end
                            if (count_next != COUNT_MAX) begin
                                count_next = count_next + COUNT_BITS'(1);
                            end
                            last_variant_next = p;
                            anchor_after_next = '1;
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        logic signed [63:0]   b64, e64;
        logic signed [PW-1:0] e_w;

        b64 = 64'(emit_start);
        e_w = emit_anchor + PW'(1);
        e64 = 64'(e_w);

        if (b64 < INT32_MIN_64) begin
            res.region_begin = INT32_MIN_64[OUT_BEGIN_BITS-1:0];
        end else if (b64 > INT32_MAX_64) begin
            res.region_begin = INT32_MAX_64[OUT_BEGIN_BITS-1:0];
        end else begin
            res.region_begin = b64[OUT_BEGIN_BITS-1:0];
        end

        if (e64 < 64'sd0) begin
            res.region_end = '0;
        end else if (e64 > INT32_MAX_64) begin
            res.region_end = INT32_MAX_64[OUT_END_BITS-1:0];
        end else begin
            res.region_end = e64[OUT_END_BITS-1:0];
        end

        res_valid = emit_now;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_gap_reg      <= MAX_GAP_RESET;
            min_var_reg      <= MIN_VAR_RESET;
            started_reg      <= 1'b0;
            region_start_reg <= '1;
            last_anchor_reg  <= '1;
            anchor_after_reg <= '1;
            last_variant_reg <= '1;
            count_reg        <= '0;
        end else begin
            if (cfg_wr_en && (cfg_addr == CFG_MAX_VARIANT_GAP)) begin
                max_gap_reg <= cfg_wr_data[GAP_BITS-1:0];
            end
            if (cfg_wr_en && (cfg_addr == CFG_MIN_VARIANTS)) begin
                min_var_reg <= cfg_wr_data[MIN_VAR_BITS-1:0];
            end
            started_reg      <= started_next;
            region_start_reg <= region_start_next;
            last_anchor_reg  <= last_anchor_next;
            anchor_after_reg <= anchor_after_next;
            last_variant_reg <= last_variant_next;
            count_reg        <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/vcrs_out_buf.sv =====
// Two-entry result stage: output register plus skid register.
// Depends on vcrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vcrs_out_buf (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               res_valid,
    input  wire vcrs_pkg::result_t  res,
    output logic                    space_ok,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output vcrs_pkg::result_t       out_res
);
    import vcrs_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (out_ready) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (!out_valid_reg || out_ready) begin
            out_valid_next = res_valid;
            out_next       = res;
        end else if (res_valid) begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign space_ok  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

`default_nettype wire

// ===== rtl/variant_cluster_region_segmenter_unit.sv =====
// Top level of the variant cluster region segmenter: stream ports and config port.
// Instantiates vcrs_core and vcrs_out_buf; depends on vcrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes one request per clock while s_tready is high, set by the single state
// update path: each position or close request is folded into the region state
// in the cycle it is accepted, and a finished region is registered in the
// output stage for the master side. Its two entries let requests keep flowing
// while a region waits; s_tready drops only when both entries are full.
module variant_cluster_region_segmenter_unit #(
    parameter int POSITION_BITS = vcrs_pkg::POSITION_BITS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [vcrs_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  wire logic [vcrs_pkg::CFG_DATA_BITS-1:0]   cfg_wr_data,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // position[30:0], is_candidate[31], is_depth_zero[32], is_anchor[33],
    // buffer_begin[64:34], buffer_end[95:65]
    input  wire logic [vcrs_pkg::S_TDATA_BITS-1:0]    s_tdata,
    // op[0]
    input  wire logic                                 s_tuser,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // region_begin[31:0], region_end[62:32], zero[63]
    output logic [vcrs_pkg::M_TDATA_BITS-1:0]         m_tdata
);
    import vcrs_pkg::*;

    logic    in_accept;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign in_accept = s_tvalid && s_tready;

    vcrs_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .in_accept     (in_accept),
        .op            (s_tuser),
        .position      (s_tdata[30:0]),
        .is_candidate  (s_tdata[31]),
        .is_depth_zero (s_tdata[32]),
        .is_anchor     (s_tdata[33]),
        .buffer_begin  (s_tdata[64:34]),
        .buffer_end    (s_tdata[95:65]),
        .res_valid     (res_valid),
        .res           (res)
    );

    vcrs_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .space_ok  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {1'b0, out_res.region_end, out_res.region_begin};

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("result stage not empty after reset");

    a_stall_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    a_full_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready && m_tready |=> s_tready && m_tvalid)
        else $error("full result stage did not drain by one");
`endif

endmodule

`default_nettype wire
